/* src/vlpd_pkg.sv */
// types and constants shared by the length-prefixed packet deframer
// no dependencies
`default_nettype none

package vlpd_pkg;

   localparam int STATUS_W = 3;
   localparam int BYTE_W   = 8;
   localparam int PLEN_W   = 16;

   localparam logic [STATUS_W-1:0] ST_DATA     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERSIZE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

   localparam logic [PLEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_byte;
      logic                last_in_packet;
      logic [PLEN_W-1:0]   packet_length;
   } result_type;

   // zero, one or two results produced by one input transaction
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } parse_out_type;

endpackage

`default_nettype wire

/* src/vlpd_req_if.sv */
// input channel: one buffer byte and its end-of-buffer mark per transaction
// no dependencies
`default_nettype none

interface vlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

/* src/vlpd_rsp_if.sv */
// result channel: one deframer result per transaction
// no dependencies
`default_nettype none

interface vlpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  payload_byte;
   logic        last_in_packet;
   logic [15:0] packet_length;

   modport source (output valid, output status, output payload_byte,
                   output last_in_packet, output packet_length, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input last_in_packet, input packet_length, output ready);
endinterface

`default_nettype wire

/* src/vlpd_parser.sv */
// header/payload parser: parse state registers and per-byte decode logic
// depends on vlpd_pkg
`default_nettype none

module vlpd_parser #(
   parameter int LEN_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    end_of_buffer,
   input  wire logic [15:0]             max_len,
   output vlpd_pkg::parse_out_type      parse_out
);
   import vlpd_pkg::*;

   localparam int HDR_MAX = (LEN_BITS + 6) / 7;
   localparam int CNT_W   = (HDR_MAX > 1) ? $clog2(HDR_MAX) : 1;
   localparam int PART_W  = LEN_BITS + 7;
   localparam int EXT_W   = (LEN_BITS > 16) ? LEN_BITS : 17;

   localparam logic [1:0] MODE_HEADER  = 2'd0;
   localparam logic [1:0] MODE_PAYLOAD = 2'd1;
   localparam logic [1:0] MODE_DROP    = 2'd2;

   logic [1:0]          mode_ff, mode_in;
   logic [LEN_BITS-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [15:0]         rem_ff, rem_in;

   logic [6:0]          value_bits;
   logic                more;
   logic [4:0]          shamt;
   logic [PART_W-1:0]   part;
   logic                over;
   logic [LEN_BITS-1:0] acc_new;
   logic [EXT_W-1:0]    acc_new_ext;
   logic [EXT_W-1:0]    acc_old_ext;
   logic [15:0]         len_new_sat;
   logic [15:0]         len_old_sat;
   logic [15:0]         rem_dec;
   logic                last;
   parse_out_type       res;

   assign value_bits  = data_byte[6:0];
   assign more        = data_byte[7];
   assign shamt       = 5'(cnt_ff) * 5'd7;
   assign part        = PART_W'(value_bits) << shamt;
   assign over        = (|part[PART_W-1:LEN_BITS]) ||
                        (more && (int'(cnt_ff) + 1 >= HDR_MAX));
   assign acc_new     = acc_ff | part[LEN_BITS-1:0];
   assign acc_new_ext = EXT_W'(acc_new);
   assign acc_old_ext = EXT_W'(acc_ff);
   assign len_new_sat = (acc_new_ext > EXT_W'(17'h0FFFF)) ? 16'hFFFF : acc_new_ext[15:0];
   assign len_old_sat = (acc_old_ext > EXT_W'(17'h0FFFF)) ? 16'hFFFF : acc_old_ext[15:0];
   assign rem_dec     = (rem_ff != 16'd0) ? rem_ff - 16'd1 : rem_ff;
   assign last        = (rem_dec == 16'd0);

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res     = '0;
      unique case (mode_ff)
         MODE_HEADER: begin
            if (over) begin
               res.count        = 2'd1;
               res.first.status = ST_OVERFLOW;
               mode_in          = end_of_buffer ? MODE_HEADER : MODE_DROP;
               acc_in           = '0;
               cnt_in           = '0;
               rem_in           = '0;
            end else if (more) begin
               if (end_of_buffer) begin
                  res.count               = 2'd1;
                  res.first.status        = ST_TRUNC;
                  res.first.packet_length = len_new_sat;
                  acc_in                  = '0;
                  cnt_in                  = '0;
               end else begin
                  acc_in = acc_new;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end else begin
               acc_in = '0;
               cnt_in = '0;
               rem_in = '0;
               if (acc_new_ext > EXT_W'(max_len)) begin
                  res.count               = 2'd1;
                  res.first.status        = ST_OVERSIZE;
                  res.first.packet_length = len_new_sat;
                  mode_in                 = end_of_buffer ? MODE_HEADER : MODE_DROP;
               end else if (acc_new == '0) begin
                  res.count                = 2'd1;
                  res.first.status         = ST_EMPTY;
                  res.first.last_in_packet = 1'b1;
               end else if (end_of_buffer) begin
                  res.count               = 2'd1;
                  res.first.status        = ST_TRUNC;
                  res.first.packet_length = len_new_sat;
               end else begin
                  mode_in = MODE_PAYLOAD;
                  acc_in  = acc_new;
                  rem_in  = len_new_sat;
               end
            end
         end
         MODE_PAYLOAD: begin
            res.count                = 2'd1;
            res.first.status         = ST_DATA;
            res.first.payload_byte   = data_byte;
            res.first.last_in_packet = last;
            res.first.packet_length  = len_old_sat;
            rem_in                   = rem_dec;
            if (last || end_of_buffer) begin
               mode_in = MODE_HEADER;
               acc_in  = '0;
               cnt_in  = '0;
               rem_in  = '0;
            end
            if (!last && end_of_buffer) begin
               res.count                = 2'd2;
               res.second.status        = ST_TRUNC;
               res.second.packet_length = len_old_sat;
            end
         end
         default: begin
            if (end_of_buffer) begin
               mode_in = MODE_HEADER;
               acc_in  = '0;
               cnt_in  = '0;
               rem_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEADER;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
      end
   end

   always_comb begin
      parse_out       = res;
      parse_out.count = fire ? res.count : 2'd0;
   end

endmodule

`default_nettype wire

/* src/vlpd_result_fifo.sv */
// four-entry queue taking up to two results per cycle, one out per cycle when out_ready
// depends on vlpd_pkg
`default_nettype none

module vlpd_result_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire vlpd_pkg::parse_out_type parse_out,
   output logic                         room,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output vlpd_pkg::result_type         out_result
);
   import vlpd_pkg::*;

   result_type entry_ff [4];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign room       = (count_ff <= 3'd2);
   assign out_valid  = (count_ff != 3'd0);
   assign out_result = entry_ff[head_ff];
   assign pop        = out_valid && out_ready;

   always_comb begin
      head_in  = pop ? head_ff + 2'd1 : head_ff;
      tail_in  = tail_ff + parse_out.count;
      count_in = count_ff + 3'(parse_out.count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (parse_out.count != 2'd0) begin
         entry_ff[tail_ff] <= parse_out.first;
      end
      if (parse_out.count == 2'd2) begin
         entry_ff[tail_ff + 2'd1] <= parse_out.second;
      end
   end

endmodule

`default_nettype wire

/* src/varint_length_packet_deframer_core.sv */
// Length-prefixed packet deframer. Each input transaction carries one buffer
// byte; a LEB128 length header is parsed and that many payload bytes are
// passed on, with empty-packet, oversize, truncation and header-overflow
// results. One input transaction is taken per clock cycle unless input stalls
// (see below); each byte is held in an input register, and a result is offered
// on the result channel once it has been written into the result queue. A
// payload byte cut off by end of buffer yields two results; the four-entry
// result queue absorbs them, and input stalls only when it holds more than two.
// csr_write_data sets the largest accepted payload length (reset 65535).
// LEN_BITS sets the widest header value.
// depends on vlpd_pkg, vlpd_req_if, vlpd_rsp_if, vlpd_parser, vlpd_result_fifo
`default_nettype none

module varint_length_packet_deframer_core #(
   parameter int LEN_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   vlpd_req_if.sink         req_bus,
   vlpd_rsp_if.source       rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);
   import vlpd_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_eob_ff;
   logic [15:0]   max_len_ff;
   logic          room;
   logic          fire;
   logic          req_take;
   parse_out_type parse_out;
   result_type    out_result;

   assign fire        = in_valid_ff && room;
   assign req_bus.ready = !in_valid_ff || room;
   assign req_take    = req_bus.valid && req_bus.ready;
   assign in_valid_in = req_take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         max_len_ff  <= MAX_LEN_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            max_len_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.data_byte;
         in_eob_ff  <= req_bus.end_of_buffer;
      end
   end

   vlpd_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .max_len       (max_len_ff),
      .parse_out     (parse_out)
   );

   vlpd_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .parse_out  (parse_out),
      .room       (room),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_result (out_result)
   );

   assign rsp_bus.status         = out_result.status;
   assign rsp_bus.payload_byte   = out_result.payload_byte;
   assign rsp_bus.last_in_packet = out_result.last_in_packet;
   assign rsp_bus.packet_length  = out_result.packet_length;

endmodule

`default_nettype wire

/* test/tb.sv */
// self-checking testbench for varint_length_packet_deframer_core: directed table, then
// random buffers under several max-length settings and flow-control patterns
// depends on vlpd_pkg, vlpd_req_if, vlpd_rsp_if and the deframer core
`default_nettype none

module tb;
   import vlpd_pkg::*;

   localparam int LEN_BITS    = 16;
   localparam int HDR_MAX     = (LEN_BITS + 6) / 7;
   localparam int SETTLE      = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 185;
   localparam int SHOW_MAX    = 10;

   typedef enum logic [1:0] {PM_HEADER, PM_PAYLOAD, PM_DROP} parse_mode_e;
   typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_e;
   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

   typedef struct packed {
      logic       eob;
      logic [7:0] data;
   } stim_t;

   typedef struct packed {
      row_kind_e   kind;
      logic [15:0] value;
      logic        eob;
      logic        typed;
      result_type  want;
   } dir_row_t;

   localparam result_type NO_RES = '0;

   localparam dir_row_t DIRECTED [30] = '{
      '{ROW_ITEM, 16'h0000, 1'b0, 1'b1, '{ST_EMPTY,    8'h00, 1'b1, 16'h0000}},
      '{ROW_ITEM, 16'h0080, 1'b1, 1'b1, '{ST_TRUNC,    8'h00, 1'b0, 16'h0000}},
      '{ROW_ITEM, 16'h0001, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h00FF, 1'b0, 1'b1, '{ST_DATA,     8'hFF, 1'b1, 16'h0001}},
      '{ROW_ITEM, 16'h00FF, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h00FF, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0004, 1'b0, 1'b1, '{ST_OVERFLOW, 8'h00, 1'b0, 16'h0000}},
      '{ROW_ITEM, 16'h0055, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0000, 1'b1, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0080, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0080, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0080, 1'b1, 1'b1, '{ST_OVERFLOW, 8'h00, 1'b0, 16'h0000}},
      '{ROW_ITEM, 16'h0002, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h00AA, 1'b1, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0003, 1'b1, 1'b1, '{ST_TRUNC,    8'h00, 1'b0, 16'h0003}},
      '{ROW_ITEM, 16'h00FF, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h00FF, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0003, 1'b1, 1'b1, '{ST_TRUNC,    8'h00, 1'b0, 16'hFFFF}},
      '{ROW_CFG,  16'h0004, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0005, 1'b0, 1'b1, '{ST_OVERSIZE, 8'h00, 1'b0, 16'h0005}},
      '{ROW_ITEM, 16'h0011, 1'b1, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0007, 1'b1, 1'b1, '{ST_OVERSIZE, 8'h00, 1'b0, 16'h0007}},
      '{ROW_ITEM, 16'h0082, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0000, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0080, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h007F, 1'b1, 1'b0, NO_RES},
      '{ROW_CFG,  16'h0000, 1'b0, 1'b0, NO_RES},
      '{ROW_ITEM, 16'h0000, 1'b0, 1'b1, '{ST_EMPTY,    8'h00, 1'b1, 16'h0000}},
      '{ROW_ITEM, 16'h0001, 1'b1, 1'b1, '{ST_OVERSIZE, 8'h00, 1'b0, 16'h0001}},
      '{ROW_CFG,  16'hFFFF, 1'b0, 1'b0, NO_RES}
   };

   // phase five takes a random setting instead of its entry
   localparam logic [15:0] PHASE_MAX [NUM_PHASES] = '{
      16'hFFFF, 16'hFFFF, 16'h0000, 16'h0009, 16'h0001, 16'h0000, 16'h00C8, 16'hFFFF
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [15:0] csr_write_data;

   vlpd_req_if req_bus ();
   vlpd_rsp_if rsp_bus ();

   varint_length_packet_deframer_core #(
      .LEN_BITS (LEN_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // deframer model state
   parse_mode_e pmode;
   logic [31:0] len_acc;
   int unsigned hdr_cnt;
   logic [15:0] left;
   logic [15:0] max_len;

   result_type  pending_results [$];
   stim_t       frame_bytes [$];

   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;
   logic        rsp_hold;
   logic        hold_armed = 1'b0;
   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned cfg_writes = 0;
   int unsigned status_seen [5] = '{0, 0, 0, 0, 0};

   function automatic void enter_header();
      pmode   = PM_HEADER;
      len_acc = '0;
      hdr_cnt = 0;
      left    = '0;
   endfunction

   function automatic logic [15:0] sat_len(input logic [31:0] v);
      return (v > 32'h0000FFFF) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic result_type make_result(input logic [2:0] st, input logic [7:0] b,
                                              input logic last, input logic [15:0] plen);
      result_type r;
      r.status         = st;
      r.payload_byte   = b;
      r.last_in_packet = last;
      r.packet_length  = plen;
      return r;
   endfunction

   function automatic int unsigned parse_byte(input logic [7:0] b, input logic eob,
                                              output result_type r0, output result_type r1);
      logic [63:0] part;
      logic        more;
      logic        over;
      logic        last;
      logic [15:0] plen;
      int unsigned n;
      r0 = '0;
      r1 = '0;
      n  = 0;
      case (pmode)
         PM_HEADER: begin
            more = b[7];
            part = 64'(b[6:0]) << (7 * (hdr_cnt & 7));
            over = ((part >> LEN_BITS) != 0) || (more && (hdr_cnt + 1 >= HDR_MAX));
            if (over) begin
               r0 = make_result(ST_OVERFLOW, 8'h00, 1'b0, 16'h0000);
               n  = 1;
               if (eob) enter_header();
               else pmode = PM_DROP;
            end else begin
               len_acc = len_acc | part[31:0];
               hdr_cnt++;
               if (more) begin
                  if (eob) begin
                     r0 = make_result(ST_TRUNC, 8'h00, 1'b0, sat_len(len_acc));
                     n  = 1;
                     enter_header();
                  end
               end else if (len_acc > 32'(max_len)) begin
                  r0 = make_result(ST_OVERSIZE, 8'h00, 1'b0, sat_len(len_acc));
                  n  = 1;
                  if (eob) enter_header();
                  else pmode = PM_DROP;
               end else if (len_acc == 0) begin
                  r0 = make_result(ST_EMPTY, 8'h00, 1'b1, 16'h0000);
                  n  = 1;
                  enter_header();
               end else if (eob) begin
                  r0 = make_result(ST_TRUNC, 8'h00, 1'b0, sat_len(len_acc));
                  n  = 1;
                  enter_header();
               end else begin
                  pmode   = PM_PAYLOAD;
                  left    = len_acc[15:0];
                  hdr_cnt = 0;
               end
            end
         end
         PM_PAYLOAD: begin
            plen = sat_len(len_acc);
            if (left > 0) left--;
            last = (left == 0);
            r0 = make_result(ST_DATA, b, last, plen);
            n  = 1;
            if (last) begin
               enter_header();
            end else if (eob) begin
               r1 = make_result(ST_TRUNC, 8'h00, 1'b0, plen);
               n  = 2;
               enter_header();
            end
         end
         default: begin
            if (eob) enter_header();
         end
      endcase
      return n;
   endfunction

   task automatic check_result(input result_type got);
      result_type want;
      if (pending_results.size() == 0) begin
         fail_count++;
         if (fail_count <= SHOW_MAX)
            $display("unexpected result: st=%0d byte=%02h last=%0b len=%0d",
                     got.status, got.payload_byte, got.last_in_packet, got.packet_length);
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         status_seen[want.status]++;
         if (want.status !== got.status || want.payload_byte !== got.payload_byte ||
             want.last_in_packet !== got.last_in_packet ||
             want.packet_length !== got.packet_length) begin
            fail_count++;
            if (fail_count <= SHOW_MAX)
               $display("mismatch: expected st=%0d byte=%02h last=%0b len=%0d, got st=%0d byte=%02h last=%0b len=%0d",
                        want.status, want.payload_byte, want.last_in_packet, want.packet_length,
                        got.status, got.payload_byte, got.last_in_packet, got.packet_length);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status         = rsp_bus.status;
         got.payload_byte   = rsp_bus.payload_byte;
         got.last_in_packet = rsp_bus.last_in_packet;
         got.packet_length  = rsp_bus.packet_length;
         check_result(got);
      end
      rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= snk_stall_pct);
   end

   // long receiver hold-off so that the result queue fills and input stalls
   initial begin
      rsp_hold = 1'b0;
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic void set_flow(input flow_e f);
      case (f)
         FLOW_SRC_IDLE:  begin src_idle_pct = 62; snk_stall_pct = 0;  end
         FLOW_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 62; end
         FLOW_BOTH:      begin src_idle_pct = 29; snk_stall_pct = 29; end
         default:        begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      endcase
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      stim_t s;
      s.eob  = 1'b0;
      s.data = b;
      frame_bytes.push_back(s);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eob, input logic typed,
                            input result_type typed_res);
      result_type  r0;
      result_type  r1;
      int unsigned n;
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.end_of_buffer <= eob;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      n = parse_byte(b, eob, r0, r1);
      if (typed) begin
         pending_results.push_back(typed_res);
      end else begin
         if (n > 0) pending_results.push_back(r0);
         if (n > 1) pending_results.push_back(r1);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_max(input logic [15:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      max_len = v;
      cfg_writes++;
   endtask

   // random buffers, each closed by an end-of-buffer byte
   task automatic run_items(input int unsigned count);
      int unsigned goal;
      int unsigned r;
      int unsigned k;
      int unsigned p;
      int unsigned i;
      int unsigned npk;
      int unsigned plen;
      int unsigned minh;
      int unsigned nhdr;
      stim_t       s;
      goal = items_sent + count;
      while (items_sent < goal) begin
         frame_bytes.delete();
         r = $urandom_range(99);
         if (r < 12) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
         end else if (r < 18) begin
            push_byte({1'b1, 7'($urandom_range(127))});
            push_byte({1'b1, 7'($urandom_range(127))});
            if ($urandom_range(1)) push_byte({1'b1, 7'($urandom_range(127))});
            else push_byte({1'b0, 7'($urandom_range(4, 127))});
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(255)));
         end else begin
            npk = $urandom_range(1, 3);
            for (p = 0; p < npk; p++) begin
               k = $urandom_range(99);
               if (k < 8) plen = 0;
               else if (k < 75) plen = $urandom_range(1, 12);
               else if (k < 88) plen = $urandom_range(13, 140);
               else if (max_len != 16'hFFFF) plen = $urandom_range(int'(max_len) + 1, 65535);
               else plen = $urandom_range(1, 12);
               minh = (plen < 128) ? 1 : (plen < 16384) ? 2 : 3;
               nhdr = ($urandom_range(99) < 20) ? $urandom_range(minh, HDR_MAX) : minh;
               for (i = 0; i < nhdr; i++)
                  push_byte({(i + 1 < nhdr), 7'(plen >> (7 * i))});
               if (plen > max_len) begin
                  repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(255)));
                  break;
               end
               repeat (plen) push_byte(8'($urandom_range(255)));
            end
            if (r < 32) begin
               k = $urandom_range(0, frame_bytes.size() - 1);
               while (frame_bytes.size() > k + 1) frame_bytes.delete(frame_bytes.size() - 1);
            end
         end
         frame_bytes[frame_bytes.size() - 1].eob = 1'b1;
         while (frame_bytes.size() != 0) begin
            s = frame_bytes.pop_front();
            send_item(s.data, s.eob, 1'b0, NO_RES);
         end
      end
   endtask

   initial begin
      int unsigned ph;
      logic [15:0] val;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = 8'h00;
      req_bus.end_of_buffer = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_write_enable      = 1'b0;
      csr_write_data        = 16'h0000;
      max_len               = 16'hFFFF;
      enter_header();
      set_flow(FLOW_FREE);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CFG)
            write_max(DIRECTED[i].value);
         else
            send_item(DIRECTED[i].value[7:0], DIRECTED[i].eob, DIRECTED[i].typed,
                      DIRECTED[i].want);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         val = (ph == 5) ? 16'($urandom_range(65535)) : PHASE_MAX[ph];
         write_max(val);
         set_flow(flow_e'(ph % 4));
         run_items(PHASE_ITEMS);
      end

      // backpressure: receiver holds off while input keeps coming, then sender waits
      write_max(16'hFFFF);
      set_flow(FLOW_FREE);
      hold_armed = 1'b1;
      run_items(120);
      drain();
      run_items(80);
      drain();

      $display("run covered %0d input transactions and %0d results over %0d max-length writes",
               items_sent, results_checked, cfg_writes);
      $display("results: data %0d, empty %0d, oversize %0d, truncated %0d, overflow %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
